[src/lds_pkg.sv]
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types, constants and helpers for the LED driver SPI frame sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lds_pkg;

    localparam int CHANNELS = 16;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int GRAY_BYTES      = 2 * CHANNELS;
    localparam int FUNC_BYTES      = 34;
    localparam int FUNC_SEVEN_FROM = 18;
    localparam int LOOP_LAST       = 33;

    localparam int IDX_MAX = (GRAY_BYTES > FUNC_BYTES) ? GRAY_BYTES : FUNC_BYTES;
    localparam int IDX_W   = $clog2(IDX_MAX + 1);

    localparam logic [7:0] FLAG_GRAY     = 8'h00;
    localparam logic [7:0] FLAG_FUNC     = 8'h01;
    localparam logic [7:0] FUNC_B16_BASE = 8'b10000101;
    localparam logic [7:0] FUNC_B16_UNBL = 8'b00000010;
    localparam logic [6:0] BRIGHT_MASK   = 7'b1111111;

    typedef enum logic [2:0] {
        OP_WRITE_GRAY = 3'd0,
        OP_START_GRAY = 3'd1,
        OP_START_FUNC = 3'd2,
        OP_START_LOOP = 3'd3,
        OP_TX_READY   = 3'd4,
        OP_RX_BYTE    = 3'd5
    } opcode_t;

    typedef struct packed {
        logic       blank_outputs;
        logic [6:0] global_brightness;
        logic [6:0] dot_correction;
    } cfg_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       seven_bit_mode;
        logic       latch_pulse;
        logic       loopback_done;
        logic       loopback_pass;
        logic       start_rejected;
        logic       busy_res;
    } res_t;

    // Function frame payload byte at position idx.
    function automatic logic [7:0] func_byte(input logic [IDX_W-1:0] idx, input cfg_t cfg);
        logic [7:0] b;
        if (idx < IDX_W'(15)) begin
            b = 8'h00;
        end else if (idx == IDX_W'(15)) begin
            b = 8'h01;
        end else if (idx == IDX_W'(16)) begin
            b = cfg.blank_outputs ? FUNC_B16_BASE : (FUNC_B16_BASE | FUNC_B16_UNBL);
        end else if (idx == IDX_W'(17)) begin
            b = {cfg.blank_outputs, cfg.global_brightness & BRIGHT_MASK};
        end else begin
            b = {1'b0, cfg.dot_correction & BRIGHT_MASK};
        end
        return b;
    endfunction

endpackage

`default_nettype wire

[src/lds_core.sv]
// ----------------------------------------------------------------------------
// lds_core
// Frame state, grayscale store and per-beat result computation.
// ----------------------------------------------------------------------------
`default_nettype none

module lds_core
    import lds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [2:0]  opcode,
    input  wire logic [3:0]  channel,
    input  wire logic [15:0] gray_value,
    input  wire logic [7:0]  data_byte,
    input  wire cfg_t        cfg,
    output res_t             res
);

    typedef enum logic [1:0] {
        KIND_IDLE = 2'd0,
        KIND_GRAY = 2'd1,
        KIND_FUNC = 2'd2,
        KIND_LOOP = 2'd3
    } kind_t;

    kind_t            kind_reg, kind_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       pattern_reg, pattern_next;
    logic [7:0]       rx_reg, rx_next;
    logic             seven_reg, seven_next;
    logic [15:0]      gray_reg [CHANNELS];

    logic             gray_we;
    logic [15:0]      word;
    logic [7:0]       rot;

    assign word = gray_reg[idx_reg[CH_W:1]];
    assign rot  = {pattern_reg[0], pattern_reg[7:1]};

    always_comb
    begin
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        pattern_next = pattern_reg;
        rx_next      = rx_reg;
        seven_next   = seven_reg;
        gray_we      = 1'b0;
        res          = '0;

        case (opcode)
            OP_WRITE_GRAY:
            begin
                gray_we = (32'(channel) < 32'(CHANNELS));
            end
            OP_START_GRAY, OP_START_FUNC, OP_START_LOOP:
            begin
                if (kind_reg != KIND_IDLE) begin
                    res.start_rejected = 1'b1;
                end else begin
                    idx_next     = '0;
                    res.tx_valid = 1'b1;
                    if (opcode == OP_START_GRAY) begin
                        kind_next   = KIND_GRAY;
                        res.tx_byte = FLAG_GRAY;
                    end else if (opcode == OP_START_FUNC) begin
                        kind_next   = KIND_FUNC;
                        res.tx_byte = FLAG_FUNC;
                    end else begin
                        kind_next    = KIND_LOOP;
                        pattern_next = data_byte;
                        res.tx_byte  = data_byte;
                    end
                end
            end
            OP_TX_READY:
            begin
                case (kind_reg)
                    KIND_GRAY:
                    begin
                        if (idx_reg >= IDX_W'(GRAY_BYTES)) begin
                            res.latch_pulse = 1'b1;
                            kind_next       = KIND_IDLE;
                        end else begin
                            res.tx_byte  = idx_reg[0] ? word[7:0] : word[15:8];
                            res.tx_valid = 1'b1;
                            idx_next     = idx_reg + 1'b1;
                        end
                    end
                    KIND_FUNC:
                    begin
                        if (idx_reg >= IDX_W'(FUNC_BYTES)) begin
                            res.latch_pulse = 1'b1;
                            seven_next      = 1'b0;
                            kind_next       = KIND_IDLE;
                        end else begin
                            if (idx_reg == IDX_W'(FUNC_SEVEN_FROM)) begin
                                seven_next = 1'b1;
                            end
                            res.tx_byte  = func_byte(idx_reg, cfg);
                            res.tx_valid = 1'b1;
                            idx_next     = idx_reg + 1'b1;
                        end
                    end
                    KIND_LOOP:
                    begin
                        if (idx_reg >= IDX_W'(LOOP_LAST)) begin
                            res.loopback_done = 1'b1;
                            res.loopback_pass = (rx_reg == rot);
                            kind_next         = KIND_IDLE;
                        end else begin
                            res.tx_byte  = pattern_reg;
                            res.tx_valid = 1'b1;
                            idx_next     = idx_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_RX_BYTE:
            begin
                if (kind_reg == KIND_LOOP) begin
                    rx_next = data_byte;
                end
            end
            default:
            begin
            end
        endcase

        res.seven_bit_mode = seven_next;
        res.busy_res       = (kind_next != KIND_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kind_reg    <= KIND_IDLE;
            idx_reg     <= '0;
            pattern_reg <= '0;
            rx_reg      <= '0;
            seven_reg   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                gray_reg[i] <= '0;
            end
        end else if (accept) begin
            kind_reg    <= kind_next;
            idx_reg     <= idx_next;
            pattern_reg <= pattern_next;
            rx_reg      <= rx_next;
            seven_reg   <= seven_next;
            if (gray_we) begin
                gray_reg[channel[CH_W-1:0]] <= gray_value;
            end
        end
    end

endmodule

`default_nettype wire

[src/lds_outbuf.sv]
// ----------------------------------------------------------------------------
// lds_outbuf
// Output register with one skid entry between the core and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module lds_outbuf
    import lds_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire res_t push_res,
    output logic      full,
    output logic      out_valid,
    input  wire logic out_stall,
    output res_t      out_res
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_reg;
    res_t skid_reg;

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || !out_stall) begin
                // output slot frees up: drain skid first, else take the new beat
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= push;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (push) begin
                out_reg <= push_res;
            end
        end else if (push) begin
            skid_reg <= push_res;
        end
    end

endmodule

`default_nettype wire

[src/led_driver_spi_frame_sequencer.sv]
// ----------------------------------------------------------------------------
// led_driver_spi_frame_sequencer
// Byte sequencer for a 16-channel PWM LED driver with an APB register port.
// ----------------------------------------------------------------------------
// Every input beat yields exactly one result beat. The frame state and
// grayscale store update at acceptance and the result lands in an output
// register backed by one skid entry, so a new beat can be taken every cycle
// while the result side keeps up, and input stall rises only once two
// results are waiting. Registers (blank at 0x0, global brightness at 0x4,
// dot correction at 0x8) should be written only while no frame is in
// progress and all results have been taken.
`default_nettype none

module led_driver_spi_frame_sequencer
    import lds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic [3:0]  channel,
    input  wire logic [15:0] gray_value,
    input  wire logic [7:0]  data_byte,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             tx_valid,
    output logic [7:0]       tx_byte,
    output logic             seven_bit_mode,
    output logic             latch_pulse,
    output logic             loopback_done,
    output logic             loopback_pass,
    output logic             start_rejected,
    output logic             busy_res
);

    typedef enum logic [1:0] {
        REG_BLANK  = 2'd0,
        REG_BRIGHT = 2'd1,
        REG_DOT    = 2'd2
    } reg_idx_t;

    cfg_t cfg_reg;
    logic cfg_wr;
    logic accept;
    logic full;
    res_t core_res;
    res_t out_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.blank_outputs     <= 1'b0;
            cfg_reg.global_brightness <= 7'd127;
            cfg_reg.dot_correction    <= 7'd127;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_BLANK:  cfg_reg.blank_outputs     <= pwdata[0];
                REG_BRIGHT: cfg_reg.global_brightness <= pwdata[6:0];
                REG_DOT:    cfg_reg.dot_correction    <= pwdata[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BLANK:  prdata = {31'd0, cfg_reg.blank_outputs};
            REG_BRIGHT: prdata = {25'd0, cfg_reg.global_brightness};
            REG_DOT:    prdata = {25'd0, cfg_reg.dot_correction};
            default:    prdata = '0;
        endcase
    end

    assign in_stall = full;
    assign accept   = in_valid && !full;

    lds_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (opcode),
        .channel    (channel),
        .gray_value (gray_value),
        .data_byte  (data_byte),
        .cfg        (cfg_reg),
        .res        (core_res)
    );

    lds_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_res  (core_res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign tx_valid       = out_res.tx_valid;
    assign tx_byte        = out_res.tx_byte;
    assign seven_bit_mode = out_res.seven_bit_mode;
    assign latch_pulse    = out_res.latch_pulse;
    assign loopback_done  = out_res.loopback_done;
    assign loopback_pass  = out_res.loopback_pass;
    assign start_rejected = out_res.start_rejected;
    assign busy_res       = out_res.busy_res;

endmodule

`default_nettype wire

[tb/lds_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lds_frame_checker
// Watches the register port and both beat channels of the LED driver frame
// sequencer, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------

package lds_tb_pkg;

    // Byte addresses of the configuration registers.
    localparam logic [3:0] ADDR_BLANK  = 4'h0;
    localparam logic [3:0] ADDR_BRIGHT = 4'h4;
    localparam logic [3:0] ADDR_DOT    = 4'h8;

endpackage

module lds_frame_checker
    import lds_pkg::*;
    import lds_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [3:0]  channel,
    input  logic [15:0] gray_value,
    input  logic [7:0]  data_byte,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        tx_valid,
    input  logic [7:0]  tx_byte,
    input  logic        seven_bit_mode,
    input  logic        latch_pulse,
    input  logic        loopback_done,
    input  logic        loopback_pass,
    input  logic        start_rejected,
    input  logic        busy_res,

    output int          mismatches,
    output int          outstanding
);

    typedef enum logic [1:0] {
        FRAME_IDLE = 2'd0,
        FRAME_GRAY = 2'd1,
        FRAME_FUNC = 2'd2,
        FRAME_LOOP = 2'd3
    } frame_t;

    // Shadow of the sequencer state and its registers
    frame_t      frame;
    logic [5:0]  byte_pos;
    logic [15:0] gray_words [CHANNELS];
    logic [7:0]  pattern;
    logic [7:0]  last_rx;
    logic        seven_bit;
    logic        cfg_blank;
    logic [6:0]  cfg_bright;
    logic [6:0]  cfg_dot;

    res_t expected_results [$];
    res_t got;
    res_t want;
    int   fail_total  = 0;
    int   beats_taken = 0;

    function automatic logic [7:0] function_payload(input logic [5:0] idx);
        logic [7:0] b;
        if (idx < 6'd15)
        begin
            b = 8'h00;
        end
        else if (idx == 6'd15)
        begin
            b = 8'h01;
        end
        else if (idx == 6'd16)
        begin
            b = cfg_blank ? FUNC_B16_BASE : (FUNC_B16_BASE | FUNC_B16_UNBL);
        end
        else if (idx == 6'd17)
        begin
            b = {cfg_blank, cfg_bright};
        end
        else
        begin
            b = {1'b0, cfg_dot};
        end
        return b;
    endfunction

    // Advances the shadow state by one input beat and returns its result.
    function automatic res_t sequence_beat(input logic [2:0] op, input logic [3:0] ch,
                                           input logic [15:0] gv, input logic [7:0] db);
        res_t        r;
        logic [15:0] word;
        logic [7:0]  rotated;
        r = '0;
        case (op)
            OP_WRITE_GRAY:
            begin
                if (int'(ch) < CHANNELS)
                    gray_words[ch] = gv;
            end
            OP_START_GRAY, OP_START_FUNC, OP_START_LOOP:
            begin
                if (frame != FRAME_IDLE)
                begin
                    r.start_rejected = 1'b1;
                end
                else
                begin
                    byte_pos   = '0;
                    r.tx_valid = 1'b1;
                    if (op == OP_START_GRAY)
                    begin
                        frame     = FRAME_GRAY;
                        r.tx_byte = FLAG_GRAY;
                    end
                    else if (op == OP_START_FUNC)
                    begin
                        frame     = FRAME_FUNC;
                        r.tx_byte = FLAG_FUNC;
                    end
                    else
                    begin
                        frame     = FRAME_LOOP;
                        pattern   = db;
                        r.tx_byte = db;
                    end
                end
            end
            OP_TX_READY:
            begin
                if (frame == FRAME_GRAY)
                begin
                    if (byte_pos >= GRAY_BYTES)
                    begin
                        r.latch_pulse = 1'b1;
                        frame         = FRAME_IDLE;
                    end
                    else
                    begin
                        word       = gray_words[byte_pos[4:1]];
                        r.tx_byte  = byte_pos[0] ? word[7:0] : word[15:8];
                        r.tx_valid = 1'b1;
                        byte_pos   = byte_pos + 6'd1;
                    end
                end
                else if (frame == FRAME_FUNC)
                begin
                    if (byte_pos >= FUNC_BYTES)
                    begin
                        r.latch_pulse = 1'b1;
                        seven_bit     = 1'b0;
                        frame         = FRAME_IDLE;
                    end
                    else
                    begin
                        // serial unit drops to 7-bit characters for dot correction
                        if (byte_pos == FUNC_SEVEN_FROM)
                            seven_bit = 1'b1;
                        r.tx_byte  = function_payload(byte_pos);
                        r.tx_valid = 1'b1;
                        byte_pos   = byte_pos + 6'd1;
                    end
                end
                else if (frame == FRAME_LOOP)
                begin
                    if (byte_pos >= LOOP_LAST)
                    begin
                        rotated         = {pattern[0], pattern[7:1]};
                        r.loopback_done = 1'b1;
                        r.loopback_pass = (last_rx == rotated);
                        frame           = FRAME_IDLE;
                    end
                    else
                    begin
                        r.tx_byte  = pattern;
                        r.tx_valid = 1'b1;
                        byte_pos   = byte_pos + 6'd1;
                    end
                end
            end
            OP_RX_BYTE:
            begin
                if (frame == FRAME_LOOP)
                    last_rx = db;
            end
            default:
            begin
            end
        endcase
        r.seven_bit_mode = seven_bit;
        r.busy_res       = (frame != FRAME_IDLE);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        fail_total++;
    endtask

    task automatic check_field(input string name, input logic [7:0] seen, input logic [7:0] exp);
        if (seen !== exp)
            report_mismatch($sformatf("beat %0d %s: got %0h, expected %0h",
                                      beats_taken, name, seen, exp));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame      = FRAME_IDLE;
            byte_pos   = '0;
            pattern    = '0;
            last_rx    = '0;
            seven_bit  = 1'b0;
            cfg_blank  = 1'b0;
            cfg_bright = 7'd127;
            cfg_dot    = 7'd127;
            for (int i = 0; i < CHANNELS; i++)
                gray_words[i] = '0;
            expected_results.delete();
            outstanding <= 0;
            mismatches  <= fail_total;
        end
        else
        begin
            // results are registered, so a result beat never belongs to the
            // input beat taken at the same edge: pop before push
            if (out_valid && !out_stall)
            begin
                got = {tx_valid, tx_byte, seven_bit_mode, latch_pulse, loopback_done,
                       loopback_pass, start_rejected, busy_res};
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result beat %0d with nothing pending (%0h)",
                                              beats_taken, got));
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
                    check_field("tx_byte", got.tx_byte, want.tx_byte);
                    check_field("seven_bit_mode", 8'(got.seven_bit_mode),
                                8'(want.seven_bit_mode));
                    check_field("latch_pulse", 8'(got.latch_pulse), 8'(want.latch_pulse));
                    check_field("loopback_done", 8'(got.loopback_done),
                                8'(want.loopback_done));
                    check_field("loopback_pass", 8'(got.loopback_pass),
                                8'(want.loopback_pass));
                    check_field("start_rejected", 8'(got.start_rejected),
                                8'(want.start_rejected));
                    check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
                end
                beats_taken++;
            end

            if (in_valid && !in_stall)
                expected_results.push_back(sequence_beat(opcode, channel, gray_value, data_byte));

            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_BLANK:  cfg_blank  = pwdata[0];
                    ADDR_BRIGHT: cfg_bright = pwdata[6:0];
                    ADDR_DOT:    cfg_dot    = pwdata[6:0];
                    default:
                    begin
                    end
                endcase
            end

            outstanding <= expected_results.size();
            mismatches  <= fail_total;
        end
    end

endmodule

[tb/led_driver_spi_frame_sequencer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_driver_spi_frame_sequencer_tb
// Drives gray, function and loopback frames with random content, noise and
// broken frames through the sequencer under several register settings, with
// random idling and stalls on both channels; a checker predicts the results.
// ----------------------------------------------------------------------------

module led_driver_spi_frame_sequencer_tb;

    import lds_pkg::*;
    import lds_tb_pkg::*;

    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    localparam int NUM_PHASES  = 8;
    localparam int PHASE_BEATS = 100;
    localparam int MAX_GAP     = 12;
    localparam int LONG_HOLD   = 200;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 16;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [2:0]  opcode     = '0;
    logic [3:0]  channel    = '0;
    logic [15:0] gray_value = '0;
    logic [7:0]  data_byte  = '0;

    logic        out_valid;
    logic        out_stall  = 1'b1;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        seven_bit_mode;
    logic        latch_pulse;
    logic        loopback_done;
    logic        loopback_pass;
    logic        start_rejected;
    logic        busy_res;

    int mismatches;
    int outstanding;

    bit sender_calm    = 1'b0;
    bit receiver_calm  = 1'b0;
    bit long_hold_req  = 1'b0;
    int phase_beats    = 0;
    int idle_cycles    = 0;

    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    led_driver_spi_frame_sequencer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .channel        (channel),
        .gray_value     (gray_value),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tx_valid       (tx_valid),
        .tx_byte        (tx_byte),
        .seven_bit_mode (seven_bit_mode),
        .latch_pulse    (latch_pulse),
        .loopback_done  (loopback_done),
        .loopback_pass  (loopback_pass),
        .start_rejected (start_rejected),
        .busy_res       (busy_res)
    );

    lds_frame_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .channel        (channel),
        .gray_value     (gray_value),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tx_valid       (tx_valid),
        .tx_byte        (tx_byte),
        .seven_bit_mode (seven_bit_mode),
        .latch_pulse    (latch_pulse),
        .loopback_done  (loopback_done),
        .loopback_pass  (loopback_pass),
        .start_rejected (start_rejected),
        .busy_res       (busy_res),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    task automatic send_beat(input logic [2:0] op, input logic [3:0] ch,
                             input logic [15:0] gv, input logic [7:0] db);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        channel    <= ch;
        gray_value <= gv;
        data_byte  <= db;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        phase_beats++;
    endtask

    task automatic send_op(input logic [2:0] op);
        send_beat(op, 4'($urandom()), 16'($urandom()), 8'($urandom()));
    endtask

    // Leaves psel high; the caller closes the transfer after the last write.
    task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // Upper bits of each word are random (zero half the time for blank); only the low field is meaningful.
    task automatic configure(input logic blank, input logic [6:0] bright, input logic [6:0] dot);
        write_reg(ADDR_BLANK, {$urandom_range(0, 1) ? 31'($urandom()) : 31'd0, blank});
        write_reg(ADDR_BRIGHT, {25'($urandom()), bright});
        write_reg(ADDR_DOT, {25'($urandom()), dot});
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Closes any frame left open, then waits for every result beat.
    task automatic drain_frames();
        repeat (FUNC_BYTES + 2)
            send_op(OP_TX_READY);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic noise_beat();
        send_op(3'($urandom_range(0, 7)));
    endtask

    // Body of an open frame: tx ready beats with noise and, for loopback, rx bytes mixed in, sometimes cut short.
    task automatic frame_body(input int ready_beats, input bit is_loop, input logic [7:0] pat);
        for (int i = 0; i < ready_beats; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                return;
            if ($urandom_range(0, 7) == 0)
                noise_beat();
            if (is_loop && (i == ready_beats - 1 || $urandom_range(0, 9) == 0))
            begin
                if ($urandom_range(0, 1))
                    send_beat(OP_RX_BYTE, 4'($urandom()), 16'($urandom()), {pat[0], pat[7:1]});
                else
                    send_op(OP_RX_BYTE);
            end
            send_op(OP_TX_READY);
        end
    endtask

    task automatic run_sequence();
        int         kind;
        logic [7:0] pat;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2:
            begin
                repeat ($urandom_range(0, 3))
                    send_op(OP_WRITE_GRAY);
                send_op(OP_START_GRAY);
                frame_body(GRAY_BYTES + 1, 1'b0, 8'h00);
            end
            3, 4:
            begin
                send_op(OP_START_FUNC);
                frame_body(FUNC_BYTES + 1, 1'b0, 8'h00);
            end
            5, 6:
            begin
                pat = 8'($urandom());
                send_beat(OP_START_LOOP, 4'($urandom()), 16'($urandom()), pat);
                frame_body(LOOP_LAST + 1, 1'b1, pat);
            end
            7:
            begin
                repeat ($urandom_range(1, 4))
                    send_op(OP_WRITE_GRAY);
            end
            default:
            begin
                repeat ($urandom_range(1, 4))
                    noise_beat();
            end
        endcase
    endtask

    // Result side: random stall per beat, plus one long hold-off on request.
    initial
    begin
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end
            wait_cycles = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic       blank;
        logic [6:0] bright;
        logic [6:0] dot;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        configure(1'b0, 7'd127, 7'd127);

        // idle corner cases, rejected starts, gray write during a frame
        send_op(OP_TX_READY);
        send_beat(OP_RX_BYTE, 4'h0, 16'h0000, 8'hFF);
        send_op(OP_UNUSED_6);
        send_op(OP_UNUSED_7);
        send_beat(OP_WRITE_GRAY, 4'd0, 16'hFFFF, 8'h00);
        send_beat(OP_WRITE_GRAY, 4'd15, 16'h0000, 8'hFF);
        send_beat(OP_WRITE_GRAY, 4'd1, 16'h8001, 8'h00);
        send_beat(OP_START_GRAY, 4'hF, 16'hFFFF, 8'hFF);
        send_op(OP_START_FUNC);
        send_beat(OP_START_LOOP, 4'h0, 16'h0000, 8'hA5);
        send_op(OP_START_GRAY);
        send_op(OP_TX_READY);
        send_beat(OP_WRITE_GRAY, 4'd0, 16'h1234, 8'h00);
        send_op(OP_TX_READY);
        send_op(OP_TX_READY);
        send_op(OP_TX_READY);
        send_beat(OP_RX_BYTE, 4'hF, 16'hFFFF, 8'h5A);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_frames();
            case (phase)
                0: configure(1'b1, 7'd0, 7'd0);
                1: configure(1'b0, 7'd127, 7'd0);
                2: configure(1'b1, 7'd127, 7'd127);
                3: configure(1'b0, 7'd0, 7'd127);
                default:
                begin
                    blank  = 1'($urandom());
                    bright = 7'($urandom());
                    dot    = 7'($urandom());
                    configure(blank, bright, dot);
                end
            endcase
            sender_calm   = (phase == 3);
            receiver_calm = (phase == 3) || (phase == 5);
            phase_beats   = 0;
            if (phase == 2)
            begin
                // keep offering beats back to back while results are held off
                long_hold_req = 1'b1;
                sender_calm   = 1'b1;
                repeat (3) run_sequence();
                sender_calm   = 1'b0;
            end
            while (phase_beats < PHASE_BEATS)
                run_sequence();
        end

        drain_frames();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
